// ===== hdl/event_time_priority_queue_defines.svh =====
// assertion macros for the event time priority queue
`ifndef EVENT_TIME_PRIORITY_QUEUE_DEFINES_SVH
`define EVENT_TIME_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define ETPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event queue next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define ETPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event queue same-cycle check failed");

`endif

// ===== hdl/etpq_pkg.sv =====
// shared types and codes of the event time priority queue
package etpq_pkg;

    localparam int TIME_W   = 48;
    localparam int NODE_W   = 2;
    localparam int SERVER_W = 4;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 6;

    // operation codes on the kind input
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP_OUTSIDE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXTRACTED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXTRACT_EMPTY = 3'd4;

    // one stored event record, 56 bits
    typedef struct packed {
        logic [TIME_W-1:0]   ev_time;
        logic                ev_type;
        logic [NODE_W-1:0]   ev_node;
        logic [SERVER_W-1:0] ev_server;
        logic                ev_outside;
    } entry_t;

    // per-beat shift control broadcast to every cell
    typedef struct packed {
        logic shift_in;   // insert: make room and load the new record
        logic shift_out;  // extract: every cell takes its right neighbour
    } cell_ctrl_t;

endpackage

// ===== hdl/etpq_cell.sv =====
// one cell of the sorted shift chain
module etpq_cell (
    input  logic                clk,
    input  etpq_pkg::cell_ctrl_t ctrl,
    input  etpq_pkg::entry_t    new_entry,
    input  logic                occupied,
    input  etpq_pkg::entry_t    left_entry,
    input  logic                left_ge,
    input  etpq_pkg::entry_t    right_entry,
    output etpq_pkg::entry_t    entry,
    output logic                ge
);

    etpq_pkg::entry_t entry_reg;
    etpq_pkg::entry_t entry_next;

    // empty cells and later-or-equal times give way to the new record
    assign ge    = !occupied || (entry_reg.ev_time >= new_entry.ev_time);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_out)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.shift_in)
        begin
            if (left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/event_time_priority_queue.sv =====
// top level of the event time priority queue: cell chain, fill count and result register
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------------------
//  command   start, busy            kind, event_time, job_event, node,
//                                   server_index, from_outside
//  result    done (one-cycle beat)  status, out_time, out_type, out_node,
//                                   out_server, out_from_outside, occupancy
//
// all cells compare against the new time at once and shift by one place, so busy
// never rises and a beat may follow every cycle
// the result beat appears on the cycle after the command beat, for exactly one cycle
// reset clears the fill count and the result strobe; cell contents are not reset
// the receiver cannot stall, so nothing is held back on the result side
module event_time_priority_queue #(
    parameter int CAPACITY   = 32,
    parameter int NODE_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [47:0] event_time,
    input  logic        job_event,
    input  logic [2:0]  node,
    input  logic [3:0]  server_index,
    input  logic        from_outside,
    output logic        done,
    output logic [2:0]  status,
    output logic [47:0] out_time,
    output logic        out_type,
    output logic [1:0]  out_node,
    output logic [3:0]  out_server,
    output logic        out_from_outside,
    output logic [5:0]  occupancy
);

`include "event_time_priority_queue_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // fill count: cells below it hold valid records, in time order
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                                done_reg;
    logic [etpq_pkg::STATUS_W-1:0]       status_reg;
    logic [etpq_pkg::STATUS_W-1:0]       status_next;
    etpq_pkg::entry_t                    result_reg;
    etpq_pkg::entry_t                    result_next;
    logic [etpq_pkg::OCC_W-1:0]          occ_reg;

    etpq_pkg::entry_t    new_entry;
    etpq_pkg::cell_ctrl_t ctrl;
    etpq_pkg::entry_t    cell_q [CAPACITY];
    logic [CAPACITY-1:0] cell_ge;

    logic accept;
    logic node_ok;
    logic is_full;
    logic is_empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign node_ok  = (32'(node) < NODE_COUNT);
    assign is_full  = (count_reg == CAP_CNT);
    assign is_empty = (count_reg == '0);

    // incoming record; node width narrows to the stored two bits
    assign new_entry.ev_time    = event_time;
    assign new_entry.ev_type    = job_event;
    assign new_entry.ev_node    = node[1:0];
    assign new_entry.ev_server  = server_index;
    assign new_entry.ev_outside = from_outside;

    // decide the beat: insert shifts right from the insertion point, extract shifts left
    always_comb
    begin
        ctrl.shift_in  = 1'b0;
        ctrl.shift_out = 1'b0;
        count_next     = count_reg;
        status_next    = etpq_pkg::ST_INSERTED;
        result_next    = '0;
        if (kind == etpq_pkg::KIND_INSERT)
        begin
            if (!node_ok)
            begin
                status_next = etpq_pkg::ST_DROP_OUTSIDE;
            end
            else if (is_full)
            begin
                status_next = etpq_pkg::ST_DROP_FULL;
            end
            else
            begin
                status_next   = etpq_pkg::ST_INSERTED;
                ctrl.shift_in = accept;
                count_next    = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = etpq_pkg::ST_EXTRACT_EMPTY;
            end
            else
            begin
                status_next    = etpq_pkg::ST_EXTRACTED;
                ctrl.shift_out = accept;
                result_next    = cell_q[0];
                count_next     = count_reg - 1'b1;
            end
        end
    end

    // chain of cells; cell i is occupied when its place lies below the fill count
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            etpq_pkg::entry_t left_e;
            etpq_pkg::entry_t right_e;
            logic             left_g;

            if (gi == 0)
            begin : g_first
                // front cell never takes from the left
                assign left_e = new_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_inner
                assign left_e = cell_q[gi-1];
                assign left_g = cell_ge[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_e = cell_q[gi];
            end
            else
            begin : g_body
                assign right_e = cell_q[gi+1];
            end

            etpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .occupied    (IDX < count_reg),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .entry       (cell_q[gi]),
                .ge          (cell_ge[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
            occ_reg    <= etpq_pkg::OCC_W'(count_next);
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign out_time         = result_reg.ev_time;
    assign out_type         = result_reg.ev_type;
    assign out_node         = result_reg.ev_node;
    assign out_server       = result_reg.ev_server;
    assign out_from_outside = result_reg.ev_outside;
    assign occupancy        = occ_reg;

    // fill count never passes the number of cells
    `ETPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_CNT)
    // every accepted beat gives exactly one result beat on the next cycle
    `ETPQ_ASSERT_NEXT(a_beat_result, accept, done)
    // an extract on an empty queue reports empty with cleared fields
    `ETPQ_ASSERT_NEXT(a_empty_extract, accept && kind == etpq_pkg::KIND_EXTRACT && is_empty,
        status == etpq_pkg::ST_EXTRACT_EMPTY && out_time == '0 && occupancy == '0)
    // a good insert into a non-full queue grows the count by one
    `ETPQ_ASSERT_NEXT(a_insert_grow, accept && kind == etpq_pkg::KIND_INSERT && node_ok &&
        !is_full, count_reg == $past(count_reg) + 1'b1)

endmodule
